/* hw/rtl/mrc_pkg.sv */
`default_nettype none

package mrc_pkg;

  // crc-16 as used on the serial line (reflected form)
  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  // function codes with extra reply checks
  localparam logic [6:0] FN_READ_HOLDING   = 7'h03;
  localparam logic [6:0] FN_WRITE_SINGLE   = 7'h06;
  localparam logic [6:0] FN_WRITE_MULTIPLE = 7'h10;

  // exception replies carry the function code with this bit set
  localparam logic [7:0] EXC_MARK = 8'h80;

  // address and length limits
  localparam logic [7:0]  SLAVE_MAX      = 8'd247;
  localparam logic [15:0] READ_COUNT_MAX = 16'd125;
  localparam logic [8:0]  MIN_LEN        = 9'd5;
  localparam logic [8:0]  ECHO_MIN_LEN   = 9'd8;

  // bits of the mismatch flags
  localparam int MM_SLAVE   = 0;
  localparam int MM_FUNC    = 1;
  localparam int MM_PAYLOAD = 2;

  // widths of the packed input and output tdata
  localparam int IN_DATA_W  = 64;
  localparam int OUT_DATA_W = 40;

  typedef enum logic {
    REQ_START = 1'b0,
    REQ_BYTE  = 1'b1
  } req_type_t;

  typedef enum logic {
    KIND_REG    = 1'b0,
    KIND_STATUS = 1'b1
  } out_kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_CRC_ERR   = 2'd1,
    ST_MISMATCH  = 2'd2,
    ST_EXCEPTION = 2'd3
  } status_t;

  typedef struct packed {
    req_type_t   req_type;
    logic [7:0]  expected_slave;
    logic [6:0]  function_code;
    logic [7:0]  expected_len;
    logic [15:0] first_word;
    logic [15:0] second_word;
    logic [7:0]  byte_value;
  } req_t;

  typedef struct packed {
    out_kind_t   out_kind;
    logic [6:0]  reg_index;
    logic [15:0] reg_value;
    status_t     status;
    logic [7:0]  exception_code;
  } rsp_t;

endpackage

`default_nettype wire

/* hw/rtl/mrc_crc_byte.sv */
`default_nettype none

module mrc_crc_byte
  import mrc_pkg::*;
(
  input  wire logic [15:0] crc_in,
  input  wire logic [7:0]  data,
  output logic      [15:0] crc_out
);

  // eight shift steps of the reflected crc, unrolled
  always_comb begin
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_out = c;
  end

endmodule

`default_nettype wire

/* hw/rtl/mrc_frame.sv */
`default_nettype none

module mrc_frame
  import mrc_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic item_valid,
  input  wire req_t item,
  output logic      rsp_valid,
  output rsp_t      rsp
);

  localparam int POS_W = $clog2(MAX_FRAME);
  localparam int LEN_W = $clog2(MAX_FRAME + 1);
  localparam logic [8:0] MAX_LEN9 = 9'(MAX_FRAME);

  // frame state
  logic              frame_active, frame_active_next;
  logic [15:0]       running_crc, running_crc_next;
  logic [POS_W-1:0]  byte_position, byte_position_next;
  logic [LEN_W-1:0]  frame_length, frame_length_next;
  logic [7:0]        want_slave, want_slave_next;
  logic [6:0]        want_function, want_function_next;
  logic [15:0]       echo_words [2];
  logic [15:0]       echo_words_next [2];
  logic [15:0]       crc_held, crc_held_next;
  logic [7:0]        low_crc_byte, low_crc_byte_next;
  logic [7:0]        high_data_byte, high_data_byte_next;
  logic [2:0]        mismatch_flags, mismatch_flags_next;
  logic              exception_flag, exception_flag_next;

  logic [15:0] crc_fed;

  mrc_crc_byte u_crc (
    .crc_in  (running_crc),
    .data    (item.byte_value),
    .crc_out (crc_fed)
  );

  // step logic for one item
  always_comb begin
    logic [8:0]       len9;
    logic [LEN_W-1:0] len_eff;
    logic [LEN_W:0]   pos_ext;
    logic             exc_now;
    logic [2:0]       mm;
    logic [7:0]       b;
    logic [7:0]       idx8;
    logic [15:0]      echo_w;
    logic [7:0]       echo_b;
    logic [15:0]      got;
    status_t          st;

    frame_active_next   = frame_active;
    running_crc_next    = running_crc;
    byte_position_next  = byte_position;
    frame_length_next   = frame_length;
    want_slave_next     = want_slave;
    want_function_next  = want_function;
    echo_words_next[0]  = echo_words[0];
    echo_words_next[1]  = echo_words[1];
    crc_held_next       = crc_held;
    low_crc_byte_next   = low_crc_byte;
    high_data_byte_next = high_data_byte;
    mismatch_flags_next = mismatch_flags;
    exception_flag_next = exception_flag;
    rsp_valid           = 1'b0;
    rsp                 = '0;

    len9    = {1'b0, item.expected_len};
    len_eff = frame_length;
    pos_ext = '0;
    exc_now = exception_flag;
    mm      = mismatch_flags;
    b       = item.byte_value;
    idx8    = 8'(byte_position) - 8'd4;
    echo_w  = (byte_position < POS_W'(4)) ? echo_words[0] : echo_words[1];
    echo_b  = byte_position[0] ? echo_w[7:0] : echo_w[15:8];
    got     = {b, low_crc_byte};
    st      = ST_OK;

    if (item.req_type == REQ_START) begin
      // arm a new frame, dropping any frame in progress
      if (len9 < MIN_LEN) begin
        len9 = MIN_LEN;
      end else if (len9 > MAX_LEN9) begin
        len9 = MAX_LEN9;
      end
      mm = '0;
      if (item.expected_slave == 8'd0 || item.expected_slave > SLAVE_MAX) begin
        mm[MM_SLAVE] = 1'b1;
      end
      if (item.function_code == FN_READ_HOLDING &&
          (item.second_word == 16'd0 || item.second_word > READ_COUNT_MAX)) begin
        mm[MM_PAYLOAD] = 1'b1;
      end
      if ((item.function_code == FN_WRITE_SINGLE ||
           item.function_code == FN_WRITE_MULTIPLE) && len9 < ECHO_MIN_LEN) begin
        mm[MM_PAYLOAD] = 1'b1;
      end
      frame_active_next   = 1'b1;
      running_crc_next    = CRC_INIT;
      byte_position_next  = '0;
      frame_length_next   = LEN_W'(len9);
      want_slave_next     = item.expected_slave;
      want_function_next  = item.function_code;
      echo_words_next[0]  = item.first_word;
      echo_words_next[1]  = item.second_word;
      crc_held_next       = '0;
      low_crc_byte_next   = '0;
      high_data_byte_next = '0;
      mismatch_flags_next = mm;
      exception_flag_next = 1'b0;
    end else if (frame_active) begin
      // function byte: exception reply shrinks the frame
      if (byte_position == POS_W'(1)) begin
        if (b == ({1'b0, want_function} | EXC_MARK)) begin
          exc_now = 1'b1;
          len_eff = LEN_W'(MIN_LEN);
        end else if (b != {1'b0, want_function}) begin
          mm[MM_FUNC] = 1'b1;
        end
      end
      pos_ext = (LEN_W + 1)'(byte_position);
      exception_flag_next = exc_now;
      frame_length_next   = len_eff;

      if (pos_ext + (LEN_W + 1)'(2) < {1'b0, len_eff}) begin
        // header and data bytes go through the crc
        running_crc_next   = crc_fed;
        byte_position_next = byte_position + POS_W'(1);
        if (byte_position == POS_W'(0)) begin
          if (b != want_slave) begin
            mm[MM_SLAVE] = 1'b1;
          end
        end else if (byte_position == POS_W'(1)) begin
          // handled above
        end else if (exc_now) begin
          high_data_byte_next = b;
        end else if (want_function == FN_READ_HOLDING) begin
          if (byte_position == POS_W'(2)) begin
            if (b != {echo_words[1][6:0], 1'b0}) begin
              mm[MM_PAYLOAD] = 1'b1;
            end
          end else if (byte_position[0]) begin
            high_data_byte_next = b;
          end else begin
            rsp_valid          = 1'b1;
            rsp.out_kind       = KIND_REG;
            rsp.reg_index      = idx8[7:1];
            rsp.reg_value      = {high_data_byte, b};
            rsp.status         = ST_OK;
            rsp.exception_code = '0;
          end
        end else if ((want_function == FN_WRITE_SINGLE ||
                      want_function == FN_WRITE_MULTIPLE) &&
                     byte_position <= POS_W'(5)) begin
          if (b != echo_b) begin
            mm[MM_PAYLOAD] = 1'b1;
          end
        end
      end else if (LEN_W'(byte_position) != len_eff - LEN_W'(1)) begin
        // low crc byte
        crc_held_next      = running_crc;
        low_crc_byte_next  = b;
        byte_position_next = byte_position + POS_W'(1);
      end else begin
        // high crc byte: close the frame and report
        frame_active_next  = 1'b0;
        byte_position_next = '0;
        if (got != crc_held) begin
          st = ST_CRC_ERR;
        end else if (mm[MM_SLAVE]) begin
          st = ST_MISMATCH;
        end else if (exc_now) begin
          st = ST_EXCEPTION;
        end else if (mm[MM_FUNC] || mm[MM_PAYLOAD]) begin
          st = ST_MISMATCH;
        end else begin
          st = ST_OK;
        end
        rsp_valid          = 1'b1;
        rsp.out_kind       = KIND_STATUS;
        rsp.reg_index      = '0;
        rsp.reg_value      = '0;
        rsp.status         = st;
        rsp.exception_code = exc_now ? high_data_byte : 8'h00;
      end
      mismatch_flags_next = mm;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_active   <= 1'b0;
      running_crc    <= CRC_INIT;
      byte_position  <= '0;
      frame_length   <= '0;
      want_slave     <= '0;
      want_function  <= '0;
      echo_words[0]  <= '0;
      echo_words[1]  <= '0;
      crc_held       <= '0;
      low_crc_byte   <= '0;
      high_data_byte <= '0;
      mismatch_flags <= '0;
      exception_flag <= 1'b0;
    end else if (item_valid) begin
      frame_active   <= frame_active_next;
      running_crc    <= running_crc_next;
      byte_position  <= byte_position_next;
      frame_length   <= frame_length_next;
      want_slave     <= want_slave_next;
      want_function  <= want_function_next;
      echo_words[0]  <= echo_words_next[0];
      echo_words[1]  <= echo_words_next[1];
      crc_held       <= crc_held_next;
      low_crc_byte   <= low_crc_byte_next;
      high_data_byte <= high_data_byte_next;
      mismatch_flags <= mismatch_flags_next;
      exception_flag <= exception_flag_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/modbus_rtu_response_checker.sv */
// Modbus RTU reply checker, master side.
// Input stream: a start item (tuser = 0) arms the checker with the expected
// slave, function code, reply length and the two request words; byte items
// (tuser = 1) then carry the received reply bytes one at a time. Bytes that
// arrive with no frame armed are dropped without a result.
// Output stream: tuser = 0 is a function 3 register word, emitted as soon as
// its two data bytes are in; tuser = 1 is the final status of the frame
// (ok, crc error, mismatch, slave exception plus its code), sent at the
// last crc byte. An item gives at most one result.
// Timing: one item per cycle while the output is not blocked. An item sits in
// the input register, where the crc byte update and the compares run, and its
// result is loaded into the output register when the item moves on, which is
// what raises m_axis_tvalid.
// Stalls: the output register holds its item while m_axis_tready is low; the
// input register keeps accepting while the output is free or being drained,
// so s_axis_tready drops only when both registers are full and blocked.
// Reset: clears both valid bits and disarms the frame; the crc restarts at
// 0xFFFF on the next start item.
`default_nettype none

module modbus_rtu_response_checker
  import mrc_pkg::*;
#(
  parameter int MAX_FRAME = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  // expected_slave, function_code, expected_len, first_word, second_word,
  // byte_value, zero pad
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
  // req_type
  input  wire logic                  s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  // reg_index, reg_value, status, exception_code, zero pad
  output logic      [OUT_DATA_W-1:0] m_axis_tdata,
  // out_kind
  output logic                       m_axis_tuser
);

  logic in_valid;
  req_t in_item;
  req_t s_item;
  logic advance;
  logic rsp_valid;
  rsp_t rsp;
  logic out_valid;
  rsp_t out_rsp;

  // unpack the input item
  always_comb begin
    s_item.req_type       = req_type_t'(s_axis_tuser);
    s_item.expected_slave = s_axis_tdata[7:0];
    s_item.function_code  = s_axis_tdata[14:8];
    s_item.expected_len   = s_axis_tdata[22:15];
    s_item.first_word     = s_axis_tdata[38:23];
    s_item.second_word    = s_axis_tdata[54:39];
    s_item.byte_value     = s_axis_tdata[62:55];
  end

  assign advance       = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_item <= s_item;
    end
  end

  mrc_frame #(
    .MAX_FRAME (MAX_FRAME)
  ) u_frame (
    .clk        (clk),
    .rst        (rst),
    .item_valid (advance),
    .item       (in_item),
    .rsp_valid  (rsp_valid),
    .rsp        (rsp)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= rsp_valid;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && rsp_valid) begin
      out_rsp <= rsp;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_rsp.out_kind;
  assign m_axis_tdata  = {7'b0, out_rsp.exception_code, out_rsp.status,
                          out_rsp.reg_value, out_rsp.reg_index};

endmodule

`default_nettype wire

/* tb/modbus_rtu_response_checker_tb.sv */
`default_nettype none

module modbus_rtu_response_checker_tb;
  import mrc_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASE_ITEMS = 325;

  typedef logic [7:0] byte_list_t[$];

  // tracks the reply being checked and the results it must produce
  class reply_scoreboard;
    bit          armed;
    logic [15:0] crc_acc;
    int          pos_now;
    int          frame_len;
    logic [7:0]  slave_want;
    logic [6:0]  func_want;
    logic [15:0] addr_word;
    logic [15:0] data_word;
    logic [15:0] crc_snap;
    logic [7:0]  crc_lo;
    logic [7:0]  data_hi;
    logic [2:0]  mm;
    bit          exc;
    rsp_t        due_replies[$];
    int          errors;
    int          words_seen;
    int          status_seen[4];

    function new();
      armed      = 1'b0;
      crc_acc    = CRC_INIT;
      pos_now    = 0;
      frame_len  = 0;
      slave_want = '0;
      func_want  = '0;
      addr_word  = '0;
      data_word  = '0;
      crc_snap   = '0;
      crc_lo     = '0;
      data_hi    = '0;
      mm         = '0;
      exc        = 1'b0;
      errors     = 0;
      words_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    // one byte of the reflected crc-16
    static function logic [15:0] crc_byte(logic [15:0] c, logic [7:0] b);
      int k;
      c = c ^ {8'h00, b};
      for (k = 0; k < 8; k++) c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      return c;
    endfunction

    // advance the reply state by one accepted item, queue any result it causes
    function void predict_reply(req_t r);
      logic [7:0]  b;
      logic [15:0] w;
      int          p;
      rsp_t        e;
      if (r.req_type == REQ_START) begin
        armed      = 1'b1;
        crc_acc    = CRC_INIT;
        pos_now    = 0;
        frame_len  = (r.expected_len < MIN_LEN) ? int'(MIN_LEN) : int'(r.expected_len);
        slave_want = r.expected_slave;
        func_want  = r.function_code;
        addr_word  = r.first_word;
        data_word  = r.second_word;
        crc_snap   = '0;
        crc_lo     = '0;
        data_hi    = '0;
        mm         = '0;
        exc        = 1'b0;
        if (slave_want == 8'd0 || slave_want > SLAVE_MAX) mm[MM_SLAVE] = 1'b1;
        if (func_want == FN_READ_HOLDING && (data_word == 16'd0 || data_word > READ_COUNT_MAX))
          mm[MM_PAYLOAD] = 1'b1;
        if ((func_want == FN_WRITE_SINGLE || func_want == FN_WRITE_MULTIPLE) &&
            frame_len < ECHO_MIN_LEN)
          mm[MM_PAYLOAD] = 1'b1;
        return;
      end
      if (!armed) return;
      b = r.byte_value;
      p = pos_now;
      // function byte: an exception reply shrinks to five bytes
      if (p == 1) begin
        if (b == ({1'b0, func_want} | EXC_MARK)) begin
          exc       = 1'b1;
          frame_len = 5;
        end else if (b != {1'b0, func_want}) begin
          mm[MM_FUNC] = 1'b1;
        end
      end
      if (p + 2 < frame_len) begin
        // body byte, covered by the crc
        crc_acc = crc_byte(crc_acc, b);
        pos_now = p + 1;
        if (p == 0) begin
          if (b != slave_want) mm[MM_SLAVE] = 1'b1;
        end else if (p == 1) begin
          // handled above
        end else if (exc) begin
          data_hi = b;
        end else if (func_want == FN_READ_HOLDING) begin
          if (p == 2) begin
            if (b != {data_word[6:0], 1'b0}) mm[MM_PAYLOAD] = 1'b1;
          end else if (p % 2 == 1) begin
            data_hi = b;
          end else begin
            e           = '0;
            e.out_kind  = KIND_REG;
            e.reg_index = 7'((p - 4) / 2);
            e.reg_value = {data_hi, b};
            e.status    = ST_OK;
            due_replies.push_back(e);
          end
        end else if ((func_want == FN_WRITE_SINGLE || func_want == FN_WRITE_MULTIPLE) &&
                     p <= 5) begin
          w = (p < 4) ? addr_word : data_word;
          if (b != (p[0] ? w[7:0] : w[15:8])) mm[MM_PAYLOAD] = 1'b1;
        end
      end else if (p != frame_len - 1) begin
        // low crc byte
        crc_snap = crc_acc;
        crc_lo   = b;
        pos_now  = p + 1;
      end else begin
        // high crc byte closes the frame
        armed      = 1'b0;
        pos_now    = 0;
        e          = '0;
        e.out_kind = KIND_STATUS;
        if ({b, crc_lo} != crc_snap) e.status = ST_CRC_ERR;
        else if (mm[MM_SLAVE]) e.status = ST_MISMATCH;
        else if (exc) e.status = ST_EXCEPTION;
        else if (mm[MM_FUNC] || mm[MM_PAYLOAD]) e.status = ST_MISMATCH;
        else e.status = ST_OK;
        e.exception_code = exc ? data_hi : 8'h00;
        due_replies.push_back(e);
      end
    endfunction

    function void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    // compare one accepted result with the oldest expectation
    function void compare_reply(rsp_t got);
      rsp_t e;
      if (due_replies.size() == 0) begin
        $error("result with nothing expected: kind %0d index %0d value %0h status %0d code %0h",
               got.out_kind, got.reg_index, got.reg_value, got.status, got.exception_code);
        errors++;
        return;
      end
      e = due_replies.pop_front();
      check_field("out_kind", e.out_kind, got.out_kind);
      check_field("reg_index", e.reg_index, got.reg_index);
      check_field("reg_value", e.reg_value, got.reg_value);
      check_field("status", e.status, got.status);
      check_field("exception_code", e.exception_code, got.exception_code);
      if (e.out_kind == KIND_REG) words_seen++;
      else status_seen[e.status]++;
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;

  reply_scoreboard sb = new();
  int cycles = 0;
  int src_idle_pct = 0;
  int snk_stall_pct = 0;
  int sent_items = 0;
  int frame_items = 0;

  modbus_rtu_response_checker dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver stalls and result checking
  always @(posedge clk) begin : result_side
    rsp_t got;
    cycles <= cycles + 1;
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.out_kind       = out_kind_t'(m_axis_tuser);
      got.reg_index      = m_axis_tdata[6:0];
      got.reg_value      = m_axis_tdata[22:7];
      got.status         = status_t'(m_axis_tdata[24:23]);
      got.exception_code = m_axis_tdata[32:25];
      sb.compare_reply(got);
    end
  end

  // present one item and hold it until the block takes it
  task automatic send_item(input req_t r);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.req_type;
    s_axis_tdata  <= {1'b0, r.byte_value, r.second_word, r.first_word, r.expected_len,
                      r.function_code, r.expected_slave};
    do @(posedge clk); while (!s_axis_tready);
    sb.predict_reply(r);
    sent_items++;
  endtask

  task automatic send_start(input logic [7:0] slave, input logic [6:0] fn,
                            input logic [7:0] len, input logic [15:0] w1,
                            input logic [15:0] w2);
    req_t r;
    r                = req_t'({$urandom, $urandom});
    r.req_type       = REQ_START;
    r.expected_slave = slave;
    r.function_code  = fn;
    r.expected_len   = len;
    r.first_word     = w1;
    r.second_word    = w2;
    send_item(r);
    frame_items++;
  endtask

  // unused fields carry random bits on byte items
  task automatic send_byte(input logic [7:0] b);
    req_t r;
    r            = req_t'({$urandom, $urandom});
    r.req_type   = REQ_BYTE;
    r.byte_value = b;
    send_item(r);
  endtask

  task automatic send_frame(input byte_list_t bytes, input int keep);
    int i;
    for (i = 0; i < keep; i++) begin
      send_byte(bytes[i]);
      frame_items++;
    end
  endtask

  // append the crc, low byte first
  function automatic byte_list_t seal(byte_list_t body);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = reply_scoreboard::crc_byte(c, body[i]);
    body.push_back(c[7:0]);
    body.push_back(c[15:8]);
    return body;
  endfunction

  // one reply, mostly well formed, sometimes damaged or cut short
  task automatic play_frame();
    byte_list_t  body;
    logic [7:0]  slave;
    logic [7:0]  fbyte;
    logic [6:0]  fn;
    logic [15:0] w1;
    logic [15:0] w2;
    int          pick;
    int          cnt;
    int          len;
    int          reply_len;
    int          keep;
    int          k;
    pick  = $urandom_range(0, 99);
    slave = 8'($urandom_range(1, 247));
    if ($urandom_range(0, 24) == 0)
      slave = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(248, 255));
    w1 = 16'($urandom);
    w2 = 16'($urandom);
    body = {};
    if (pick >= 95) begin
      // junk start with any field values, then a few bytes
      send_start(8'($urandom), 7'($urandom), 8'($urandom), w1, w2);
      repeat ($urandom_range(0, 12)) begin
        send_byte(8'($urandom));
        frame_items++;
      end
      return;
    end
    if (pick < 33) begin
      // read holding registers: count byte, then the words
      fn  = FN_READ_HOLDING;
      cnt = ($urandom_range(0, 19) == 0) ? $urandom_range(1, 125) : $urandom_range(1, 6);
      w2  = 16'(cnt);
      if ($urandom_range(0, 19) == 0)
        w2 = $urandom_range(0, 1) ? 16'd0 : 16'($urandom_range(126, 65535));
      len = 5 + 2 * cnt;
      fbyte = {1'b0, fn};
      body.push_back(slave);
      body.push_back(fbyte);
      body.push_back(8'(2 * cnt));
    end else if (pick < 66) begin
      // single and multiple write echo address and value or count
      fn  = (pick < 50) ? FN_WRITE_SINGLE : FN_WRITE_MULTIPLE;
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 7) : 8;
      fbyte = {1'b0, fn};
      body.push_back(slave);
      body.push_back(fbyte);
      body.push_back(w1[15:8]);
      body.push_back(w1[7:0]);
      body.push_back(w2[15:8]);
      body.push_back(w2[7:0]);
    end else if (pick < 78) begin
      // exception reply, five bytes, no longer than the armed length
      fn  = 7'($urandom);
      len = $urandom_range(5, 40);
      fbyte = {1'b0, fn} | EXC_MARK;
      body.push_back(slave);
      body.push_back(fbyte);
      body.push_back(8'($urandom));
    end else begin
      fn  = 7'($urandom);
      len = ($urandom_range(0, 19) == 0) ? $urandom_range(25, 255) : $urandom_range(5, 24);
      fbyte = {1'b0, fn};
      body.push_back(slave);
      body.push_back(fbyte);
    end
    reply_len = (pick >= 66 && pick < 78) ? 5 : len;
    while (body.size() > reply_len - 2) void'(body.pop_back());
    while (body.size() < reply_len - 2) body.push_back(8'($urandom));
    // wrong address or function byte before the crc is made
    k = $urandom_range(0, 99);
    if (k < 5) body[0] = 8'($urandom);
    else if (k < 10) body[1] = 8'($urandom);
    body = seal(body);
    // bit error anywhere, crc included
    if ($urandom_range(0, 9) == 0) begin
      k = $urandom_range(0, body.size() - 1);
      body[k] = body[k] ^ (8'h01 << $urandom_range(0, 7));
    end
    keep = body.size();
    if ($urandom_range(0, 19) == 0) keep = $urandom_range(0, body.size() - 1);
    send_start(slave, fn, 8'(len), w1, w2);
    send_frame(body, keep);
    // stray bytes after the reply
    if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
  endtask

  // run ends at the cycle limit if the block stops answering
  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    byte_list_t body;
    int         phase;
    int         mark;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // byte with no frame armed
    send_byte(8'hA5);
    // all-zero start: length raised to five, address zero is invalid
    send_start(8'd0, 7'd0, 8'd0, 16'h0000, 16'h0000);
    body = {};
    repeat (3) body.push_back(8'h00);
    body = seal(body);
    send_frame(body, body.size());
    // top address, top function, exception reply
    send_start(8'd247, 7'h7F, 8'd255, 16'hFFFF, 16'hFFFF);
    body = {};
    body.push_back(8'd247);
    body.push_back(8'hFF);
    body.push_back(8'h0B);
    body = seal(body);
    send_frame(body, body.size());
    // read of one register holding all ones
    send_start(8'd17, FN_READ_HOLDING, 8'd7, 16'h0000, 16'd1);
    body = {};
    body.push_back(8'd17);
    body.push_back({1'b0, FN_READ_HOLDING});
    body.push_back(8'd2);
    body.push_back(8'hFF);
    body.push_back(8'hFF);
    body = seal(body);
    send_frame(body, body.size());
    // a new start drops the reply in progress
    send_start(8'd1, FN_WRITE_MULTIPLE, 8'd8, 16'h0001, 16'd2);
    send_byte(8'd1);
    send_byte({1'b0, FN_WRITE_MULTIPLE});
    send_start(8'd1, FN_WRITE_SINGLE, 8'd8, 16'h1234, 16'hABCD);
    body = {};
    body.push_back(8'd1);
    body.push_back({1'b0, FN_WRITE_SINGLE});
    body.push_back(8'h12);
    body.push_back(8'h34);
    body.push_back(8'hAB);
    body.push_back(8'hCD);
    body = seal(body);
    send_frame(body, body.size());

    // random replies under four idle and stall mixes
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          src_idle_pct  = 0;
          snk_stall_pct = 0;
        end
        1: begin
          src_idle_pct  = 68;
          snk_stall_pct = 0;
        end
        2: begin
          src_idle_pct  = 0;
          snk_stall_pct = 68;
        end
        default: begin
          src_idle_pct  = 7;
          snk_stall_pct = 7;
        end
      endcase
      mark = frame_items;
      while (frame_items - mark < PHASE_ITEMS) play_frame();
      // hold the sender until every expected result is back
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while (sb.due_replies.size() != 0);
    end

    // let any stray result show up
    repeat (20) @(posedge clk);
    $display("%0d items sent; %0d register words and %0d frame statuses checked",
             sent_items, sb.words_seen,
             sb.status_seen[0] + sb.status_seen[1] + sb.status_seen[2] + sb.status_seen[3]);
    $display("statuses: ok %0d, crc error %0d, mismatch %0d, exception %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_CRC_ERR],
             sb.status_seen[ST_MISMATCH], sb.status_seen[ST_EXCEPTION]);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
